### sv/streaming_substring_search_top_macros.svh
// Assertion macros shared by the substring search RTL.
`ifndef STREAMING_SUBSTRING_SEARCH_TOP_MACROS_SVH
`define STREAMING_SUBSTRING_SEARCH_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define SSS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `SSS_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

### sv/sss_pkg.sv
// Shared types and constants for the streaming substring search.
package sss_pkg;

    localparam int NEEDLE_MAX_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 16;
    localparam int BYTE_W          = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int LEN_REG_W       = 5;
    localparam int MATCH_OFFSET_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEEDLE_LOW    = 2'd0,
        CFG_NEEDLE_HIGH   = 2'd1,
        CFG_NEEDLE_LENGTH = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic advance;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] offset;
    } t_result;

endpackage

### sv/streaming_substring_search_top.sv
// Top level of the streaming substring search: cell chain, search control, output buffer.
//
//  channel   direction  signals                                   width
//  in        sink       i_in_valid / o_in_ready, i_char_in        8
//  out       source     o_out_valid / i_out_ready, o_found,       1 + 16
//                       o_match_offset
//  cfg       sink       i_cfg_valid / o_cfg_ready, i_cfg_index,   2 + 64
//                       i_cfg_data
//
// One byte per cycle while o_in_ready is high; all needle positions compared at once in the cell chain.
// A result is registered in the output buffer and offered from there after its byte is taken.
// Two-entry output buffer: input ready drops only while both entries are full.
// Synchronous reset clears the search state, needle registers and buffer.
module streaming_substring_search_top #(
    parameter int NEEDLE_MAX  = sss_pkg::NEEDLE_MAX_DEF,
    parameter int OFFSET_BITS = sss_pkg::OFFSET_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [sss_pkg::BYTE_W-1:0]         i_char_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic [sss_pkg::MATCH_OFFSET_W-1:0] o_match_offset,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sss_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import sss_pkg::*;

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int SAT_W = (OFFSET_BITS > MATCH_OFFSET_W) ? OFFSET_BITS : MATCH_OFFSET_W;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [CFG_DATA_W-1:0]  r_needle_low;
    logic [CFG_DATA_W-1:0]  r_needle_high;
    logic [LEN_REG_W-1:0]   r_needle_length;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_done;
    logic [OFFSET_BITS-1:0] n_offset;
    logic                   n_done;

    logic [NEEDLE_MAX-1:0]  zero_byte;
    logic [NEEDLE_MAX-1:0]  hit_next;
    logic [NEEDLE_MAX-1:0]  hit;
    logic [NEEDLE_MAX-1:0]  len_sel;
    logic [LEN_W-1:0]       len_lim;
    logic [LEN_W-1:0]       len;
    t_cell_ctrl             ctrl;
    logic                   in_fire;
    logic                   is_term;
    logic                   empty_hit;
    logic                   match;
    logic [OFFSET_BITS-1:0] len_m1;
    logic [OFFSET_BITS-1:0] start;
    logic [SAT_W-1:0]       start_w;
    logic                   res_valid;
    t_result                res;
    t_result                out_res;
    logic                   buf_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low    <= '0;
            r_needle_high   <= '0;
            r_needle_length <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NEEDLE_LOW:    r_needle_low    <= i_cfg_data;
                CFG_NEEDLE_HIGH:   r_needle_high   <= i_cfg_data;
                CFG_NEEDLE_LENGTH: r_needle_length <= i_cfg_data[LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Cell chain
    for (genvar g = 0; g < NEEDLE_MAX; g++) begin : g_cell
        logic [BYTE_W-1:0] needle_byte;
        logic              prev_hit;

        if (g < 8) begin : g_lo
            assign needle_byte = r_needle_low[BYTE_W*g +: BYTE_W];
        end else begin : g_hi
            assign needle_byte = r_needle_high[BYTE_W*(g-8) +: BYTE_W];
        end

        if (g == 0) begin : g_first
            assign prev_hit = 1'b1;
        end else begin : g_rest
            assign prev_hit = hit[g-1];
        end

        assign zero_byte[g] = (needle_byte == '0);
        assign len_sel[g]   = (len == LEN_W'(g + 1));

        sss_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_char        (i_char_in),
            .i_needle_byte (needle_byte),
            .i_enable      (LEN_W'(g) < len),
            .i_prev_hit    (prev_hit),
            .o_hit_next    (hit_next[g]),
            .o_hit         (hit[g])
        );
    end

    // Length in use: capped, cut at the first zero needle byte
    always_comb begin
        if (r_needle_length > LEN_REG_W'(NEEDLE_MAX)) begin
            len_lim = LEN_W'(NEEDLE_MAX);
        end else begin
            len_lim = r_needle_length[LEN_W-1:0];
        end
        len = len_lim;
        for (int i = NEEDLE_MAX - 1; i >= 0; i--) begin
            if (zero_byte[i] && (LEN_W'(i) < len_lim)) begin
                len = LEN_W'(i);
            end
        end
    end

    assign in_fire      = i_in_valid && o_in_ready;
    assign is_term      = (i_char_in == '0);
    assign ctrl.clear   = in_fire && is_term;
    assign ctrl.advance = in_fire && !is_term && !r_done && (len != '0);
    assign empty_hit    = in_fire && !is_term && !r_done && (len == '0);
    assign match        = ctrl.advance && ((hit_next & len_sel) != '0);

    assign len_m1 = OFFSET_BITS'(len) - OFFSET_BITS'(1);

    always_comb begin
        if (r_offset == OFF_MAX) begin
            start = OFF_MAX;
        end else if (r_offset >= len_m1) begin
            start = r_offset - len_m1;
        end else begin
            start = '0;
        end
        start_w = SAT_W'(start);
    end

    always_comb begin
        res_valid  = (ctrl.clear && !r_done) || empty_hit || match;
        res.found  = is_term ? (len == '0) : 1'b1;
        res.offset = '0;
        if (match) begin
            if (start_w > SAT_W'({MATCH_OFFSET_W{1'b1}})) begin
                res.offset = '1;
            end else begin
                res.offset = start_w[MATCH_OFFSET_W-1:0];
            end
        end
    end

    always_comb begin
        n_offset = r_offset;
        n_done   = r_done;
        if (ctrl.clear) begin
            n_offset = '0;
            n_done   = 1'b0;
        end else if (match || empty_hit) begin
            n_done = 1'b1;
        end else if (ctrl.advance && (r_offset != OFF_MAX)) begin
            n_offset = r_offset + OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_done   <= 1'b0;
        end else begin
            r_offset <= n_offset;
            r_done   <= n_done;
        end
    end

    sss_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_result (res),
        .o_ready  (buf_ready),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_res)
    );

    assign o_in_ready     = buf_ready;
    assign o_found        = out_res.found;
    assign o_match_offset = out_res.offset;

    `include "streaming_substring_search_top_macros.svh"

    `SSS_ASSERT(a_term_clears, i_clk, i_rst_n, ctrl.clear |=> (hit == '0 && r_offset == '0 && !r_done), "terminator left state")
    `SSS_ASSERT_NEVER(a_quiet_after_match, i_clk, i_rst_n, r_done && in_fire && !is_term && res_valid, "result after match")
    `SSS_ASSERT(a_done_holds, i_clk, i_rst_n, (r_done && !ctrl.clear) |=> r_done, "done flag dropped")
    `SSS_ASSERT(a_match_sets_done, i_clk, i_rst_n, match |=> (r_done && $stable(r_offset)), "match did not stop search")

endmodule

### sv/sss_cell.sv
// One needle position: byte compare and prefix-hit flop of the shift-and chain.
module sss_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sss_pkg::t_cell_ctrl      i_ctrl,
    input  logic [sss_pkg::BYTE_W-1:0] i_char,
    input  logic [sss_pkg::BYTE_W-1:0] i_needle_byte,
    input  logic                     i_enable,
    input  logic                     i_prev_hit,
    output logic                     o_hit_next,
    output logic                     o_hit
);

    logic r_hit;
    logic n_hit;

    assign o_hit_next = i_prev_hit && i_enable && (i_char == i_needle_byte);
    assign o_hit      = r_hit;

    always_comb begin
        n_hit = r_hit;
        if (i_ctrl.clear) begin
            n_hit = 1'b0;
        end else if (i_ctrl.advance) begin
            n_hit = o_hit_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

endmodule

### sv/sss_out_buf.sv
// Two-entry output register with skid stage for result transactions.
module sss_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sss_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output sss_pkg::t_result o_result
);

    import sss_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_fire;

    assign out_fire = r_out_valid && i_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_valid) begin
                if (!r_out_valid || out_fire) begin
                    r_out       <= i_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= i_result;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `include "streaming_substring_search_top_macros.svh"

    `SSS_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid without output")
    `SSS_ASSERT(a_skid_drains, i_clk, i_rst_n, (r_skid_valid && i_ready) |=> !r_skid_valid, "skid held")
    `SSS_ASSERT_NEVER(a_no_fill_when_full, i_clk, i_rst_n, r_skid_valid && i_valid, "write to full buffer")

endmodule

### tb/streaming_substring_search_top_test.sv
// Self-checking testbench for the streaming substring search top level.
`timescale 1ns / 100ps

module streaming_substring_search_top_test;
    import sss_pkg::*;

    localparam int          CLK_PERIOD     = 20;
    localparam int          RESET_CYCLES   = 9;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          TIMEOUT_CYCLES = 2_000_000;
    localparam int          RANDOM_ITEMS   = 800;
    localparam int          PRINT_LIMIT    = 40;
    localparam int unsigned OFFSET_CEIL    = 32'((64'd1 << OFFSET_BITS_DEF) - 64'd1);
    localparam int unsigned REPORT_CEIL    = 32'((64'd1 << MATCH_OFFSET_W) - 64'd1);

    localparam logic [BYTE_W-1:0]      TERMINATOR   = '0;
    localparam logic [BYTE_W-1:0]      FIRST_LETTER = 8'h61;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_ready;
    logic [BYTE_W-1:0]         i_char_in      = '0;
    logic                      o_out_valid;
    logic                      i_out_ready    = 1'b0;
    logic                      o_found;
    logic [MATCH_OFFSET_W-1:0] o_match_offset;
    logic                      i_cfg_valid    = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_W-1:0]    i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data     = '0;

    // predicted needle and search state
    logic [CFG_DATA_W-1:0]     needle_lo      = '0;
    logic [CFG_DATA_W-1:0]     needle_hi      = '0;
    logic [LEN_REG_W-1:0]      needle_len     = '0;
    logic [NEEDLE_MAX_DEF-1:0] prefix_hits    = '0;
    int unsigned               scan_offset    = 0;
    bit                        match_reported = 1'b0;

    t_result expected_results[$];
    int      error_count = 0;
    int      sent_chars  = 0;
    int      sink_stall  = 0;
    bit      idling_on   = 1'b1;

    streaming_substring_search_top uut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int draw_gap();
        int pick;
        if (!idling_on) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] needle_byte(input int unsigned i);
        int unsigned k;
        logic [CFG_DATA_W-1:0] word;
        k    = i & 15;
        word = (k < 8) ? needle_lo : needle_hi;
        return word[8*(k%8) +: 8];
    endfunction

    // needle ends at its first zero byte, length clamps at NEEDLE_MAX
    function automatic int unsigned needle_span();
        int unsigned lim;
        lim = (needle_len > NEEDLE_MAX_DEF) ? NEEDLE_MAX_DEF : needle_len;
        for (int unsigned i = 0; i < lim; i++)
            if (needle_byte(i) == TERMINATOR) return i;
        return lim;
    endfunction

    function automatic bit search_step(input logic [BYTE_W-1:0] c, output t_result r);
        int unsigned               span;
        int unsigned               start;
        logic [NEEDLE_MAX_DEF-1:0] eq;
        bit                        was_done;
        r    = '0;
        eq   = '0;
        span = needle_span();
        if (c == TERMINATOR) begin
            was_done       = match_reported;
            prefix_hits    = '0;
            scan_offset    = 0;
            match_reported = 1'b0;
            r.found        = (span == 0);
            return !was_done;
        end
        if (match_reported) return 1'b0;
        if (span == 0) begin
            match_reported = 1'b1;
            r.found        = 1'b1;
            return 1'b1;
        end
        for (int unsigned i = 0; i < span; i++)
            eq[i] = (needle_byte(i) == c);
        prefix_hits = {prefix_hits[NEEDLE_MAX_DEF-2:0], 1'b1} & eq;
        if (prefix_hits[span-1]) begin
            if (scan_offset >= OFFSET_CEIL)
                start = OFFSET_CEIL;
            else if (scan_offset >= span - 1)
                start = scan_offset - (span - 1);
            else
                start = 0;
            if (start > REPORT_CEIL) start = REPORT_CEIL;
            match_reported = 1'b1;
            r.found        = 1'b1;
            r.offset       = start[MATCH_OFFSET_W-1:0];
            return 1'b1;
        end
        if (scan_offset < OFFSET_CEIL) scan_offset++;
        return 1'b0;
    endfunction

    function automatic logic [2*CFG_DATA_W-1:0] pack_text(input string s);
        logic [2*CFG_DATA_W-1:0] bits;
        bits = '0;
        for (int i = 0; i < s.len() && i < NEEDLE_MAX_DEF; i++)
            bits[8*i +: 8] = s[i];
        return bits;
    endfunction

    function automatic logic [BYTE_W-1:0] haystack_byte(input int unsigned span,
                                                        input bit noisy);
        int pick;
        pick = $urandom_range(0, 9);
        if (noisy && pick == 0) return TERMINATOR;
        if (span > 0 && pick < 5) return needle_byte($urandom_range(0, span - 1));
        if (pick < 7) return FIRST_LETTER + BYTE_W'($urandom_range(0, 3));
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, what);
    endtask

    task automatic send_char(input logic [BYTE_W-1:0] c);
        int      gap;
        t_result r;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_chars++;
        if (search_step(c, r)) expected_results.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_NEEDLE_LOW:    needle_lo  = data;
            CFG_NEEDLE_HIGH:   needle_hi  = data;
            CFG_NEEDLE_LENGTH: needle_len = data[LEN_REG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_needle(input logic [2*CFG_DATA_W-1:0] bits,
                              input logic [CFG_DATA_W-1:0] len_word);
        write_reg(CFG_NEEDLE_LOW, bits[CFG_DATA_W-1:0]);
        write_reg(CFG_NEEDLE_HIGH, bits[2*CFG_DATA_W-1:CFG_DATA_W]);
        write_reg(CFG_NEEDLE_LENGTH, len_word);
        i_cfg_valid <= 1'b0;
    endtask

    // needle is empty out of reset
    task automatic test_empty_needle();
        send_text("A");
        send_char(8'hFF);
        send_char(TERMINATOR);
        send_char(TERMINATOR);
    endtask

    task automatic test_basic_match();
        wait_idle();
        set_needle(pack_text("abc"), 64'd3);
        send_text("xabc");
        send_char(TERMINATOR);
        send_text("ab");
        send_char(TERMINATOR);
    endtask

    task automatic test_length_clamp();
        logic [2*CFG_DATA_W-1:0] bits;
        bits = {64'h7F80_BFC0_DFE0_EFF0, 64'h0102_0408_1020_40FF};
        wait_idle();
        set_needle(bits, '1);
        send_char(8'hAA);
        for (int i = 0; i < NEEDLE_MAX_DEF; i++) send_char(bits[8*i +: 8]);
        send_char(TERMINATOR);
    endtask

    task automatic test_needle_zero_byte();
        logic [2*CFG_DATA_W-1:0] bits;
        bits        = pack_text("abXcd");
        bits[23:16] = TERMINATOR;
        wait_idle();
        set_needle(bits, 64'd5);
        send_text("zab");
        send_char(TERMINATOR);
    endtask

    // prefix bits left by the old needle carry into the new one
    task automatic test_midstream_change();
        logic [2*CFG_DATA_W-1:0] bits;
        wait_idle();
        set_needle(pack_text("ab"), 64'd2);
        send_text("a");
        wait_idle();
        bits = pack_text("ac");
        write_reg(CFG_NEEDLE_LOW, bits[CFG_DATA_W-1:0]);
        write_reg(CFG_UNMAPPED, '1);
        i_cfg_valid <= 1'b0;
        send_text("c");
        send_text("q");
        send_char(TERMINATOR);
    endtask

    task automatic test_random_haystacks();
        logic [2*CFG_DATA_W-1:0] bits;
        logic [CFG_DATA_W-1:0]   len_word;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [BYTE_W-1:0]       hay[$];
        int unsigned             span;
        int unsigned             n;
        int unsigned             at;
        int                      pick;
        bit                      noisy;
        sent_chars = 0;
        while (sent_chars < RANDOM_ITEMS) begin
            wait_idle();
            idling_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < NEEDLE_MAX_DEF; i++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    bits[8*i +: 8] = TERMINATOR;
                else if (pick < 10)
                    bits[8*i +: 8] = FIRST_LETTER + BYTE_W'($urandom_range(0, 3));
                else
                    bits[8*i +: 8] = BYTE_W'($urandom_range(1, 255));
            end
            len_word = {$urandom, $urandom};
            pick     = $urandom_range(0, 9);
            if (pick == 0)
                len_word[LEN_REG_W-1:0] = '0;
            else if (pick == 1)
                len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(17, 31));
            else if (pick == 2)
                len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(9, 16));
            else
                len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(1, 8));
            if ($urandom_range(0, 4) == 0) begin
                idx = CFG_INDEX_W'($urandom_range(0, 3));
                if (idx == CFG_NEEDLE_LENGTH)
                    write_reg(idx, len_word);
                else if (idx == CFG_NEEDLE_HIGH)
                    write_reg(idx, bits[2*CFG_DATA_W-1:CFG_DATA_W]);
                else
                    write_reg(idx, bits[CFG_DATA_W-1:0]);
                i_cfg_valid <= 1'b0;
            end else begin
                set_needle(bits, len_word);
            end
            span = needle_span();
            repeat ($urandom_range(1, 6)) begin
                hay.delete();
                noisy = ($urandom_range(0, 6) == 0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                : $urandom_range(0, 20);
                for (int i = 0; i < n; i++) hay.push_back(haystack_byte(span, noisy));
                if (span > 0 && $urandom_range(0, 1) == 1) begin
                    at = $urandom_range(0, n);
                    for (int i = int'(span) - 1; i >= 0; i--)
                        hay.insert(at, needle_byte(i));
                end
                if ($urandom_range(0, 9) != 0) hay.push_back(TERMINATOR);
                foreach (hay[i]) send_char(hay[i]);
            end
        end
    endtask

    // output side back-pressure
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            i_out_ready <= 1'b0;
            sink_stall--;
        end else begin
            i_out_ready <= 1'b1;
            sink_stall = draw_gap();
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                          o_found, o_match_offset));
            end else begin
                want = expected_results.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("found: got %0b, want %0b",
                                              o_found, want.found));
                if (o_match_offset !== want.offset)
                    report_mismatch($sformatf("match_offset: got %0d, want %0d",
                                              o_match_offset, want.offset));
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_needle();
        test_basic_match();
        test_length_clamp();
        test_needle_zero_byte();
        test_midstream_change();
        test_random_haystacks();
        wait_idle();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
